// ===== hw/rtl/cctd_pkg.sv =====
// Shared types, constants and register codes of the two-channel CCT dimmer.
`default_nettype none

package cctd_pkg;

  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned BAND_W  = 11;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HRS_W   = 11;
  localparam int unsigned MS_W    = 6;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 12'd4095;

  localparam logic [LEVEL_W-1:0] MIX_FS_RST   = 12'd3859;
  localparam logic [LEVEL_W-1:0] POWER_FS_RST = 12'd3853;
  localparam logic [BAND_W-1:0]  DEAD_BAND_RST = 11'd100;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd1000;

  localparam logic [LEVEL_W-1:0] MS_PER_S = 12'd1000;
  localparam logic [LEVEL_W-1:0] S_PER_H  = 12'd3600;
  localparam logic [LEVEL_W-1:0] S_PER_M  = 12'd60;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MIX_FS    = 2'd0;
  localparam cfg_idx_t CFG_POWER_FS  = 2'd1;
  localparam cfg_idx_t CFG_DEAD_BAND = 2'd2;
  localparam cfg_idx_t CFG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic               full_on;
    logic [LEVEL_W-1:0] mix_raw;
    logic [LEVEL_W-1:0] power_raw;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] warm_duty;
    logic [LEVEL_W-1:0] cold_duty;
    logic               report_valid;
    logic [HRS_W-1:0]   on_hours;
    logic [MS_W-1:0]    on_minutes;
    logic [MS_W-1:0]    on_seconds;
  } out_item_t;

  // One classified tick handed from the front end to the back end.
  typedef struct packed {
    logic               full_on;
    logic [LEVEL_W-1:0] warm;
    logic [LEVEL_W-1:0] cold;
    logic [LEVEL_W-1:0] power;
    logic               report;
    logic [TIME_W-1:0]  elapsed_ms;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cctd_if.sv =====
// Valid/ready channel interfaces for input ticks and result items.
`default_nettype none

interface cctd_in_if;
  import cctd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cctd_out_if;
  import cctd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/two_channel_cct_dimmer_with_on_timer.sv =====
// Top level of the two-channel warm/cold dimmer with on-time reporting.
//
// Every accepted tick gives exactly one result. The front end takes one tick at a time:
// both knob rescales run on their own 24-step serial dividers in parallel, so a tick
// occupies the front end from acceptance through the divide steps, classification and
// hand-over to the queue, which sets the sustained rate. The back end scales the duties
// and, on a report tick only, then splits the on time into seconds, hours, minutes
// and leftover seconds by multiplying with fixed reciprocals, one step per cycle. A short
// queue between the two ends and a result register let the front end go on accepting
// ticks while a report is being worked out or a result waits on the output. Configuration
// writes take effect at once and should only be issued while the block is idle.
`default_nettype none

module two_channel_cct_dimmer_with_on_timer #(
  parameter int unsigned QUEUE_DEPTH = cctd_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cctd_in_if.sink                          in_ch,
  cctd_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire cctd_pkg::cfg_idx_t          cfg_index,
  input  wire logic [cctd_pkg::CFG_W-1:0]  cfg_wdata
);

  import cctd_pkg::*;

  logic push_valid, push_ready;
  job_t push_data;
  logic pop_valid, pop_ready;
  job_t pop_data;

  cctd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_data  (push_data)
  );

  cctd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  cctd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cctd_div.sv =====
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none

module cctd_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [DW-1:0]      quo,
  output logic [VW-1:0]      rem
);

  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;

  always_comb begin
    trial = {rem_r, q_r[DW-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = VW'(trial - {1'b0, dsr_r});
      q_nxt   = {q_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[VW-1:0];
      q_nxt   = {q_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while a division is in progress");

endmodule

`default_nettype wire

// ===== hw/rtl/cctd_front.sv =====
// Front end: accepts ticks, rescales and snaps the knobs, runs the on/off counters.
`default_nettype none

module cctd_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  cctd_in_if.sink                        in_ch,
  input  wire logic                      cfg_we,
  input  wire cctd_pkg::cfg_idx_t        cfg_index,
  input  wire logic [cctd_pkg::CFG_W-1:0] cfg_wdata,
  output logic                           job_valid,
  input  wire logic                      job_ready,
  output cctd_pkg::job_t                 job_data
);

  import cctd_pkg::*;

  localparam int unsigned PROD_W = 2 * LEVEL_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [LEVEL_W-1:0] mix_fs_r, power_fs_r;
  logic [BAND_W-1:0]  dead_band_r;
  logic [THR_W-1:0]   thr_r;
  logic [CNT_W-1:0]   on_ticks_r, off_ticks_r;
  logic [TIME_W-1:0]  on_start_r;
  logic               full_on_r;
  logic [TIME_W-1:0]  now_r;
  job_t               job_r, job_nxt;

  logic               accept;
  logic               mix_busy, power_busy, mix_done, power_done;
  logic [PROD_W-1:0]  mix_quo, power_quo;
  logic [PROD_W-1:0]  mix_prod, power_prod;
  logic [LEVEL_W-1:0] mix_div, power_div;
  logic [LEVEL_W-1:0] mix_lvl, power_lvl;
  logic [CNT_W-1:0]   thr_ext;
  logic               lit;
  logic               classify;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [PROD_W-1:0] q);
    logic [LEVEL_W-1:0] res;
    res = (|q[PROD_W-1:LEVEL_W]) ? FULL_LEVEL : q[LEVEL_W-1:0];
    return res;
  endfunction

  function automatic logic [LEVEL_W-1:0] snap(input logic [LEVEL_W-1:0] lvl,
                                              input logic [BAND_W-1:0]  band);
    logic [LEVEL_W-1:0] band_ext;
    logic [LEVEL_W-1:0] res;
    band_ext = {1'b0, band};
    if (lvl < band_ext) begin
      res = '0;
    end else if (lvl > FULL_LEVEL - band_ext) begin
      res = FULL_LEVEL;
    end else begin
      res = lvl;
    end
    return res;
  endfunction

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == F_IDLE);

  // raw * 4095 as a shift and subtract; a zero full scale counts as one.
  assign mix_prod   = {in_ch.data.mix_raw, {LEVEL_W{1'b0}}}
                    - {{LEVEL_W{1'b0}}, in_ch.data.mix_raw};
  assign power_prod = {in_ch.data.power_raw, {LEVEL_W{1'b0}}}
                    - {{LEVEL_W{1'b0}}, in_ch.data.power_raw};
  assign mix_div    = (mix_fs_r == '0) ? LEVEL_W'(1) : mix_fs_r;
  assign power_div  = (power_fs_r == '0) ? LEVEL_W'(1) : power_fs_r;

  cctd_div #(.DW(PROD_W), .VW(LEVEL_W)) u_mix_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (mix_prod),
    .divisor  (mix_div),
    .busy     (mix_busy),
    .done     (mix_done),
    .quo      (mix_quo),
    .rem      ()
  );

  cctd_div #(.DW(PROD_W), .VW(LEVEL_W)) u_power_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (power_prod),
    .divisor  (power_div),
    .busy     (power_busy),
    .done     (power_done),
    .quo      (power_quo),
    .rem      ()
  );

  // Both dividers start together and run the same number of steps.
  assign classify  = (state_r == F_DIV) && mix_done && power_done;
  assign mix_lvl   = clamp_level(mix_quo);
  assign power_lvl = clamp_level(power_quo);
  assign thr_ext   = {1'b0, thr_r};

  always_comb begin
    job_nxt            = '0;
    job_nxt.full_on    = full_on_r;
    job_nxt.warm       = snap(mix_lvl, dead_band_r);
    job_nxt.cold       = snap(FULL_LEVEL - mix_lvl, dead_band_r);
    job_nxt.power      = snap(power_lvl, dead_band_r);
    job_nxt.elapsed_ms = now_r - on_start_r;
    lit                = full_on_r || (job_nxt.power != '0);
    job_nxt.report     = !lit && (off_ticks_r == thr_ext);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_DIV;
      end
      F_DIV: begin
        if (classify) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      mix_fs_r    <= MIX_FS_RST;
      power_fs_r  <= POWER_FS_RST;
      dead_band_r <= DEAD_BAND_RST;
      thr_r       <= THRESHOLD_RST;
      on_ticks_r  <= '0;
      off_ticks_r <= '0;
      on_start_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIX_FS:    mix_fs_r    <= cfg_wdata[LEVEL_W-1:0];
          CFG_POWER_FS:  power_fs_r  <= cfg_wdata[LEVEL_W-1:0];
          CFG_DEAD_BAND: dead_band_r <= cfg_wdata[BAND_W-1:0];
          CFG_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (classify) begin
        if (lit) begin
          off_ticks_r <= '0;
          if (on_ticks_r < thr_ext) begin
            on_ticks_r <= on_ticks_r + 1'b1;
          end else if (on_ticks_r == thr_ext) begin
            on_start_r <= now_r;
            on_ticks_r <= on_ticks_r + 1'b1;
          end
        end else begin
          on_ticks_r <= '0;
          if (off_ticks_r <= thr_ext) begin
            off_ticks_r <= off_ticks_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full_on_r <= in_ch.data.full_on;
      now_r     <= in_ch.data.now_ms;
    end
    if (classify) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = (state_r == F_PUSH);
  assign job_data  = job_r;

  a_counters_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((on_ticks_r != '0) && (off_ticks_r != '0)))
    else $error("on and off counters are both running");

  a_report_only_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_r.report) |-> (!job_r.full_on && (job_r.power == '0)))
    else $error("report raised on a lit tick");

  a_dividers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (mix_busy == power_busy) && (mix_done == power_done))
    else $error("knob dividers out of step");

endmodule

`default_nettype wire

// ===== hw/rtl/cctd_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module cctd_queue #(
  parameter int unsigned DEPTH = cctd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire cctd_pkg::job_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output cctd_pkg::job_t      rd_data
);

  import cctd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != NW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= NW'(DEPTH)) && ((cnt_r == '0) == (!rd_valid)))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/cctd_back.sv =====
// Back end: scales the duties by power and converts the on time for reports.
`default_nettype none

module cctd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire cctd_pkg::job_t job_data,
  cctd_out_if.source          out_ch
);

  import cctd_pkg::*;

  localparam int unsigned PROD_W = 2 * LEVEL_W;

  // Whole seconds of a 32-bit millisecond span fit in 23 bits.
  localparam int unsigned SEC_W = 23;

  // Rounded-up reciprocals that give exact floors of x/1000 for 32-bit x,
  // x/3600 for 23-bit x and x/60 for 12-bit x.
  localparam int unsigned MS_RW     = 29;
  localparam int unsigned HR_RW     = 24;
  localparam int unsigned MIN_RW    = 13;
  localparam logic [MS_RW-1:0]  MS_RECIP  = 29'd274877907;
  localparam logic [HR_RW-1:0]  HR_RECIP  = 24'd9544372;
  localparam logic [MIN_RW-1:0] MIN_RECIP = 13'd4370;
  localparam int unsigned MS_SHIFT  = 38;
  localparam int unsigned HR_SHIFT  = 35;
  localparam int unsigned MIN_SHIFT = 18;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_MUL  = 4'd1;
  localparam logic [3:0] B_DUTY = 4'd2;
  localparam logic [3:0] B_SEC  = 4'd3;
  localparam logic [3:0] B_HR   = 4'd4;
  localparam logic [3:0] B_REM  = 4'd5;
  localparam logic [3:0] B_MIN  = 4'd6;
  localparam logic [3:0] B_LEFT = 4'd7;
  localparam logic [3:0] B_OUT  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  job_t               job_r;
  logic [PROD_W-1:0]  prod_w_r, prod_c_r;
  logic [SEC_W-1:0]   tsec_r;
  logic [LEVEL_W-1:0] hrem_r;
  out_item_t          res_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic                      take;
  logic                      load;
  logic [TIME_W+MS_RW-1:0]   ms_prod;
  logic [SEC_W+HR_RW-1:0]    hr_prod;
  logic [SEC_W-1:0]          hr_secs;
  logic [SEC_W-1:0]          hrem_full;
  logic [LEVEL_W+MIN_RW-1:0] min_prod;
  logic [LEVEL_W-1:0]        min_secs;
  logic [LEVEL_W-1:0]        left_full;

  // p = 4096a + b = 4095a + (a + b), and a + b stays below twice 4095.
  function automatic logic [LEVEL_W-1:0] div_full(input logic [PROD_W-1:0] p);
    logic [LEVEL_W-1:0] a;
    logic [LEVEL_W:0]   s;
    logic [LEVEL_W-1:0] res;
    a   = p[PROD_W-1:LEVEL_W];
    s   = {1'b0, a} + {1'b0, p[LEVEL_W-1:0]};
    res = a + {{(LEVEL_W-1){1'b0}}, (s >= {1'b0, FULL_LEVEL})};
    return res;
  endfunction

  assign take      = job_valid && job_ready;
  assign job_ready = (state_r == B_IDLE);
  assign load      = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  // The on time is split one step per cycle: seconds, hours, seconds within
  // the hour, minutes, and the seconds left over.
  assign ms_prod   = {{MS_RW{1'b0}}, job_r.elapsed_ms} * {{TIME_W{1'b0}}, MS_RECIP};
  assign hr_prod   = {{HR_RW{1'b0}}, tsec_r} * {{SEC_W{1'b0}}, HR_RECIP};
  assign hr_secs   = {{(SEC_W-HRS_W){1'b0}}, res_r.on_hours}
                   * {{(SEC_W-LEVEL_W){1'b0}}, S_PER_H};
  assign hrem_full = tsec_r - hr_secs;
  assign min_prod  = {{MIN_RW{1'b0}}, hrem_r} * {{LEVEL_W{1'b0}}, MIN_RECIP};
  assign min_secs  = {{(LEVEL_W-MS_W){1'b0}}, res_r.on_minutes} * S_PER_M;
  assign left_full = hrem_r - min_secs;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (take) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_DUTY;
      B_DUTY: state_nxt = job_r.report ? B_SEC : B_OUT;
      B_SEC:  state_nxt = B_HR;
      B_HR:   state_nxt = B_REM;
      B_REM:  state_nxt = B_MIN;
      B_MIN:  state_nxt = B_LEFT;
      B_LEFT: state_nxt = B_OUT;
      B_OUT:  if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= job_data;
      res_r <= '0;
    end
    if (state_r == B_MUL) begin
      prod_w_r <= {{LEVEL_W{1'b0}}, job_r.warm} * {{LEVEL_W{1'b0}}, job_r.power};
      prod_c_r <= {{LEVEL_W{1'b0}}, job_r.cold} * {{LEVEL_W{1'b0}}, job_r.power};
    end
    if (state_r == B_DUTY) begin
      res_r.report_valid <= job_r.report;
      if (job_r.full_on) begin
        res_r.warm_duty <= FULL_LEVEL;
        res_r.cold_duty <= FULL_LEVEL;
      end else begin
        res_r.warm_duty <= div_full(prod_w_r);
        res_r.cold_duty <= div_full(prod_c_r);
      end
    end
    if (state_r == B_SEC) begin
      tsec_r <= ms_prod[MS_SHIFT +: SEC_W];
    end
    if (state_r == B_HR) begin
      res_r.on_hours <= hr_prod[HR_SHIFT +: HRS_W];
    end
    if (state_r == B_REM) begin
      hrem_r <= hrem_full[LEVEL_W-1:0];
    end
    if (state_r == B_MIN) begin
      res_r.on_minutes <= min_prod[MIN_SHIFT +: MS_W];
    end
    if (state_r == B_LEFT) begin
      res_r.on_seconds <= left_full[MS_W-1:0];
    end
    if (load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_idle_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.report_valid) |->
      ((out_r.on_hours == '0) && (out_r.on_minutes == '0) && (out_r.on_seconds == '0)))
    else $error("report fields set without a report");

  a_time_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (({{(LEVEL_W-MS_W){1'b0}}, out_r.on_minutes} < S_PER_M) &&
       ({{(LEVEL_W-MS_W){1'b0}}, out_r.on_seconds} < S_PER_M)))
    else $error("minutes or seconds out of range");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result changed while the receiver stalled");

endmodule

`default_nettype wire

// ===== sim/cctd_checker.sv =====
// Checker that predicts every dimmer result from the observed transactions and compares them.
module cctd_checker
  import cctd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int unsigned       mismatch_cnt,
  output int unsigned       pending_cnt,
  output int unsigned       report_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SHOWN = 10;

  logic [LEVEL_W-1:0] mix_fs;
  logic [LEVEL_W-1:0] power_fs;
  logic [BAND_W-1:0]  dead_band;
  logic [THR_W-1:0]   threshold;
  logic [CNT_W-1:0]   on_ticks;
  logic [CNT_W-1:0]   off_ticks;
  logic [TIME_W-1:0]  on_start_ms;
  out_item_t          tick_results_q[$];
  int unsigned        errors;
  int unsigned        reports;

  function automatic int unsigned rescale_knob(input logic [LEVEL_W-1:0] raw,
                                               input logic [LEVEL_W-1:0] full_scale);
    int unsigned fs;
    int unsigned lvl;
    // A full scale of zero behaves like one.
    fs  = (full_scale == '0) ? 32'd1 : 32'(full_scale);
    lvl = (32'(raw) * 32'(FULL_LEVEL)) / fs;
    return (lvl > 32'(FULL_LEVEL)) ? 32'(FULL_LEVEL) : lvl;
  endfunction

  // The low band is tested first, so overlapping bands resolve toward zero.
  function automatic int unsigned snap_level(input int unsigned lvl);
    if (lvl < 32'(dead_band)) return 0;
    if (lvl > 32'(FULL_LEVEL) - 32'(dead_band)) return 32'(FULL_LEVEL);
    return lvl;
  endfunction

  function automatic out_item_t dimmer_tick(input in_item_t t);
    int unsigned       mix_lvl;
    int unsigned       pwr_lvl;
    int unsigned       warm;
    int unsigned       cold;
    int unsigned       secs;
    int unsigned       rem;
    logic              lit;
    logic [TIME_W-1:0] elapsed;
    out_item_t         r;
    r       = '0;
    mix_lvl = rescale_knob(t.mix_raw, mix_fs);
    pwr_lvl = rescale_knob(t.power_raw, power_fs);
    if (t.full_on) begin
      r.warm_duty = FULL_LEVEL;
      r.cold_duty = FULL_LEVEL;
      lit = 1'b1;
    end else begin
      warm    = snap_level(mix_lvl);
      cold    = snap_level(32'(FULL_LEVEL) - mix_lvl);
      pwr_lvl = snap_level(pwr_lvl);
      r.warm_duty = LEVEL_W'((warm * pwr_lvl) / 32'(FULL_LEVEL));
      r.cold_duty = LEVEL_W'((cold * pwr_lvl) / 32'(FULL_LEVEL));
      lit = (pwr_lvl != 0);
    end
    if (lit) begin
      off_ticks = '0;
      if (on_ticks < CNT_W'(threshold)) begin
        on_ticks = on_ticks + 1'b1;
      end else if (on_ticks == CNT_W'(threshold)) begin
        on_start_ms = t.now_ms;
        on_ticks    = on_ticks + 1'b1;
      end
    end else begin
      on_ticks = '0;
      if (off_ticks < CNT_W'(threshold)) begin
        off_ticks = off_ticks + 1'b1;
      end else if (off_ticks == CNT_W'(threshold)) begin
        // Elapsed time wraps with the millisecond counter.
        elapsed        = t.now_ms - on_start_ms;
        secs           = 32'(elapsed) / 32'(MS_PER_S);
        rem            = secs % 32'(S_PER_H);
        r.report_valid = 1'b1;
        r.on_hours     = HRS_W'(secs / 32'(S_PER_H));
        r.on_minutes   = MS_W'(rem / 32'(S_PER_M));
        r.on_seconds   = MS_W'(rem % 32'(S_PER_M));
        off_ticks      = off_ticks + 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      mix_fs      = MIX_FS_RST;
      power_fs    = POWER_FS_RST;
      dead_band   = DEAD_BAND_RST;
      threshold   = THRESHOLD_RST;
      on_ticks    = '0;
      off_ticks   = '0;
      on_start_ms = '0;
      errors      = 0;
      reports     = 0;
      tick_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIX_FS:    mix_fs    = cfg_wdata[LEVEL_W-1:0];
          CFG_POWER_FS:  power_fs  = cfg_wdata[LEVEL_W-1:0];
          CFG_DEAD_BAND: dead_band = cfg_wdata[BAND_W-1:0];
          CFG_THRESHOLD: threshold = cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tick_results_q.push_back(dimmer_tick(in_data));
      end
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: result transaction with nothing predicted: warm %0d cold %0d",
                     $time, out_data.warm_duty, out_data.cold_duty);
          end
        end else begin
          want = tick_results_q.pop_front();
          if (want.report_valid) reports++;
          if (want.warm_duty !== out_data.warm_duty ||
              want.cold_duty !== out_data.cold_duty ||
              want.report_valid !== out_data.report_valid ||
              want.on_hours !== out_data.on_hours ||
              want.on_minutes !== out_data.on_minutes ||
              want.on_seconds !== out_data.on_seconds) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $display("%0t: mismatch, expected warm %0d cold %0d report %0b %0d:%0d:%0d",
                       $time, want.warm_duty, want.cold_duty, want.report_valid,
                       want.on_hours, want.on_minutes, want.on_seconds,
                       ", actual warm %0d cold %0d report %0b %0d:%0d:%0d",
                       out_data.warm_duty, out_data.cold_duty, out_data.report_valid,
                       out_data.on_hours, out_data.on_minutes, out_data.on_seconds);
            end
          end
        end
      end
    end
    mismatch_cnt <= errors;
    pending_cnt  <= tick_results_q.size();
    report_cnt   <= reports;
  end

endmodule

// ===== sim/tb_two_channel_cct_dimmer_with_on_timer.sv =====
// Testbench top: drives knob ticks and register writes into the dimmer and reports the verdict.
module tb_two_channel_cct_dimmer_with_on_timer import cctd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_TICKS = 1850;
  localparam int unsigned MIN_REPORTS  = 40;
  localparam int unsigned MAX_PHASES   = 40;
  localparam int unsigned DRAIN_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned LONG_HOLD    = 600;

  typedef enum int unsigned {RX_FLOW, RX_CHOPPY, RX_STALL, RX_HOLD} rx_mode_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  int unsigned        mismatch_cnt;
  int unsigned        pending_cnt;
  int unsigned        report_cnt;

  cctd_in_if  in_ch ();
  cctd_out_if out_ch ();

  bit                 valid_high;
  int unsigned        burst_left;
  logic [TIME_W-1:0]  clock_ms;
  logic [LEVEL_W-1:0] cur_pfs;
  logic [BAND_W-1:0]  cur_db;
  logic [THR_W-1:0]   cur_thr;
  int unsigned        ticks_sent;
  int unsigned        settings_done;
  int unsigned        hold_req = 0;
  int unsigned        holds_done = 0;

  two_channel_cct_dimmer_with_on_timer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cctd_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data      (in_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_data     (out_ch.data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt),
    .report_cnt   (report_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("Timeout: the run did not complete.");
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one tick and returns at the edge where the transaction happens. Bursts end in gaps.
  task automatic send_tick(input in_item_t t);
    int unsigned gap;
    if (!valid_high) begin
      in_ch.valid <= 1'b1;
      valid_high = 1'b1;
    end
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        valid_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_fields(input logic full_on, input logic [LEVEL_W-1:0] mix,
                             input logic [LEVEL_W-1:0] pwr, input logic [TIME_W-1:0] now);
    in_item_t t;
    t.full_on   = full_on;
    t.mix_raw   = mix;
    t.power_raw = pwr;
    t.now_ms    = now;
    send_tick(t);
  endtask

  // Lowers valid and waits until every predicted result has come out.
  task automatic wait_idle();
    int unsigned n;
    if (valid_high) begin
      in_ch.valid <= 1'b0;
      valid_high = 1'b0;
    end
    n = 0;
    @(posedge clk);
    while (pending_cnt != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] mix_w, input logic [CFG_W-1:0] pwr_w,
                               input logic [CFG_W-1:0] band_w, input logic [CFG_W-1:0] thr_w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIX_FS;
    cfg_wdata <= mix_w;
    @(posedge clk);
    cfg_index <= CFG_POWER_FS;
    cfg_wdata <= pwr_w;
    @(posedge clk);
    cfg_index <= CFG_DEAD_BAND;
    cfg_wdata <= band_w;
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr_w;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_pfs = pwr_w[LEVEL_W-1:0];
    cur_db  = band_w[BAND_W-1:0];
    cur_thr = thr_w[THR_W-1:0];
    settings_done++;
  endtask

  function automatic logic [LEVEL_W-1:0] pick_full_scale();
    case ($urandom_range(0, 7))
      0: return 12'd1;
      1: return FULL_LEVEL;
      2: return '0;
      default: return LEVEL_W'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic logic [BAND_W-1:0] pick_dead_band();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return BAND_W'($urandom_range(0, 2047));
      default: return BAND_W'($urandom_range(0, 300));
    endcase
  endfunction

  // Builds a tick that keeps the light on or off under the current setting.
  function automatic in_item_t make_tick(input bit lit);
    in_item_t    t;
    int unsigned fs;
    int unsigned dim_max;
    case ($urandom_range(0, 19))
      0: clock_ms = clock_ms + $urandom;
      1: clock_ms = clock_ms + $urandom_range(0, 10_000_000);
      default: clock_ms = clock_ms + $urandom_range(0, 2000);
    endcase
    t.now_ms  = clock_ms;
    t.mix_raw = ($urandom_range(0, 9) == 0) ?
                (($urandom_range(0, 1) == 0) ? '0 : FULL_LEVEL) : LEVEL_W'($urandom);
    if (lit) begin
      t.full_on = ($urandom_range(0, 3) == 0);
      // A rescaled knob is never below its raw reading, so raw >= band keeps it lit.
      t.power_raw = t.full_on ? LEVEL_W'($urandom) : LEVEL_W'($urandom_range(32'(cur_db), 4095));
    end else begin
      fs      = (cur_pfs == '0) ? 1 : 32'(cur_pfs);
      dim_max = 32'(cur_db) * fs;
      t.full_on   = 1'b0;
      t.power_raw = (dim_max == 0) ? '0 : LEVEL_W'($urandom_range(0, (dim_max - 1) / 4095));
    end
    return t;
  endfunction

  function automatic int unsigned run_len();
    if (cur_thr > 16) return $urandom_range(1, 20);
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, 32'(cur_thr) + 1);
    return 32'(cur_thr) + 1 + $urandom_range(0, 4);
  endfunction

  task automatic send_run(input bit lit, input int unsigned len);
    repeat (len) send_tick(make_tick(lit));
  endtask

  task automatic send_noise(input int unsigned n);
    in_item_t t;
    repeat (n) begin
      t.full_on   = $urandom_range(0, 1);
      t.mix_raw   = LEVEL_W'($urandom);
      t.power_raw = LEVEL_W'($urandom);
      t.now_ms    = $urandom;
      send_tick(t);
    end
  endtask

  initial begin : sink_pattern
    rx_mode_e    mode;
    int unsigned seg_len;
    out_ch.ready <= 1'b0;
    forever begin
      if (holds_done != hold_req) begin
        mode    = RX_HOLD;
        seg_len = LONG_HOLD;
        holds_done++;
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 2));
        seg_len = (mode == RX_STALL) ? $urandom_range(1, 40) : $urandom_range(1, 120);
      end
      repeat (seg_len) begin
        @(posedge clk);
        case (mode)
          RX_FLOW:   out_ch.ready <= 1'b1;
          RX_CHOPPY: out_ch.ready <= ($urandom_range(0, 2) != 0);
          default:   out_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned       phase;
    int unsigned       phase_start;
    int unsigned       phase_len;
    int unsigned       random_sent;
    logic [THR_W-1:0]  thr;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_MIX_FS;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    valid_high    = 1'b0;
    burst_left    = 0;
    clock_ms      = '0;
    ticks_sent    = 0;
    settings_done = 0;
    random_sent   = 0;
    cur_pfs = POWER_FS_RST;
    cur_db  = DEAD_BAND_RST;
    cur_thr = THRESHOLD_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: extremes of every field, rescale overflow, both switch states.
    send_fields(1'b1, 12'd0, 12'd0, 32'd0);
    send_fields(1'b0, FULL_LEVEL, FULL_LEVEL, 32'hFFFF_FFFF);
    send_fields(1'b0, 12'd0, FULL_LEVEL, 32'd1000);
    send_fields(1'b0, 12'd1930, 12'd2000, 32'd5000);
    send_fields(1'b0, 12'd50, 12'd50, 32'd6000);
    send_fields(1'b1, FULL_LEVEL, 12'd0, 32'd7000);
    wait_idle();

    // Zero mix full scale, no dead band, zero threshold; upper write bits are ignored.
    apply_setting(16'hF000, 16'h0FFF, 16'hF800, 16'h0000);
    // The first report has no latched on period behind it.
    send_fields(1'b0, 12'd0, 12'd0, 32'hFFFF_FFFF);
    send_fields(1'b0, 12'd1, FULL_LEVEL, 32'd100);
    send_fields(1'b0, 12'd0, 12'd1, 32'd200);
    send_fields(1'b0, 12'd0, 12'd0, 32'd3_723_100);
    send_fields(1'b0, 12'd2, 12'd0, 32'd3_800_000);
    send_fields(1'b1, 12'd0, 12'd0, 32'd50);
    // The time has wrapped since the latch.
    send_fields(1'b0, 12'd0, 12'd0, 32'd10);
    wait_idle();

    // Dead bands that nearly meet at mid scale, power full scale of one.
    apply_setting(16'h0FFF, 16'h0001, 16'h07FF, 16'd2);
    send_fields(1'b0, 12'd2046, 12'd1, 32'd9000);
    send_fields(1'b0, 12'd2047, 12'd1, 32'd9100);
    send_fields(1'b0, 12'd2048, 12'd2, 32'd9200);
    send_fields(1'b0, 12'd2049, 12'd0, 32'd9300);
    send_fields(1'b0, FULL_LEVEL, 12'd1, 32'd10_000);
    send_fields(1'b0, 12'd100, 12'd1, 32'd11_000);
    send_fields(1'b0, 12'd3000, 12'd1, 32'd12_000);
    send_fields(1'b1, 12'd0, 12'd0, 32'd13_000);
    send_fields(1'b0, 12'd7, 12'd0, 32'd20_000);
    send_fields(1'b0, 12'd8, 12'd0, 32'd25_000);
    send_fields(1'b0, 12'd9, 12'd0, 32'd95_432_000);
    clock_ms = 32'd95_432_000;

    // Random phases: mostly on/off runs around the threshold, some noise.
    phase = 0;
    while ((random_sent < RANDOM_TICKS || report_cnt < MIN_REPORTS) && phase < MAX_PHASES) begin
      wait_idle();
      if (phase == 0) begin
        thr = '1;
      end else if (phase == 1) begin
        thr = '0;
      end else begin
        thr = THR_W'($urandom_range(1, 12));
      end
      apply_setting({4'($urandom), pick_full_scale()}, {4'($urandom), pick_full_scale()},
                    {5'($urandom), pick_dead_band()}, thr);
      // The receiver holds off for a long stretch while ticks keep coming.
      if (phase == 1 || phase == 5) hold_req++;
      phase_len   = (cur_thr > 16) ? 60 : 180;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < phase_len) begin
        if ($urandom_range(0, 9) < 8) begin
          send_run(1'b1, run_len());
          send_run(1'b0, run_len());
        end else begin
          send_noise($urandom_range(1, 4));
        end
      end
      random_sent += ticks_sent - phase_start;
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d ticks over %0d register settings with %0d on-time reports checked.",
             ticks_sent, settings_done, report_cnt);
    $display("The result side held off %0d times for %0d cycles while ticks were offered.",
             holds_done, LONG_HOLD);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
